FILE: rtl/ciad_pkg.sv
// ----------------------------------------------------------------------------
// Context ID allocator package
// Shared constants, command codes, sequencer states and the control and
// status structs that pass between the top level and the idle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ciad_pkg;

   localparam int FIRST_ID   = 1;
   localparam int ID_COUNT   = 15;
   localparam int ID_W       = 4;
   localparam int ID_LIMIT   = (1 << ID_W) - 1;
   localparam int ID_EXT_W   = ID_W + 1;
   localparam int SLOT_W     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int LAST_SLOT  = ID_COUNT - 1;
   localparam int CMD_W      = 2;
   localparam int TIME_W     = 32;
   localparam int DELAY_W    = 23;
   localparam int DELAY_MS_W = TIME_W + 1;
   localparam int MS_PER_S   = 1000;
   localparam int VER_W      = 8;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(172800);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_IN_USE = 2'd1,
      CMD_IDLE   = 2'd2,
      CMD_TICK   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic              stamp_en;
      logic              clear_en;
      logic [SLOT_W-1:0] wr_slot;
      logic [TIME_W-1:0] stamp;
      logic [SLOT_W-1:0] rd_slot;
   } idle_ctrl_type;

   typedef struct packed {
      logic idle;
      logic expired;
   } idle_stat_type;

endpackage

`default_nettype wire

FILE: rtl/ciad_idle_table.sv
// ----------------------------------------------------------------------------
// Idle timestamp table
// Holds the idle timestamp of each pool slot in a small memory with a valid
// bit per slot, and compares the slot under inspection against the delay.
// ----------------------------------------------------------------------------
`default_nettype none

module ciad_idle_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ciad_pkg::idle_ctrl_type        ctrl,
   input  wire logic [ciad_pkg::TIME_W-1:0]     now_ms,
   input  wire logic [ciad_pkg::DELAY_MS_W-1:0] delay_ms,
   output ciad_pkg::idle_stat_type             stat
);

   logic [ciad_pkg::TIME_W-1:0] stamp_mem [ciad_pkg::ID_COUNT];
   logic [ciad_pkg::TIME_W-1:0] rd_data_ff;
   logic [ciad_pkg::SLOT_W-1:0] chk_slot_ff;
   logic [ciad_pkg::ID_COUNT-1:0] valid_ff;
   logic [ciad_pkg::ID_COUNT-1:0] valid_in;
   logic [ciad_pkg::TIME_W-1:0] elapsed;

   always_ff @(posedge clock) begin
      if (ctrl.stamp_en) begin
         stamp_mem[ctrl.wr_slot] <= ctrl.stamp;
      end
      rd_data_ff <= stamp_mem[ctrl.rd_slot];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.stamp_en) begin
         valid_in[ctrl.wr_slot] = 1'b1;
      end
      if (ctrl.clear_en) begin
         valid_in[ctrl.wr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         chk_slot_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         chk_slot_ff <= ctrl.rd_slot;
      end
   end

   // Elapsed time wraps modulo 2^32; the delay is one bit wider so that it
   // can exceed any elapsed time.
   assign elapsed      = now_ms - rd_data_ff;
   assign stat.idle    = valid_ff[chk_slot_ff];
   assign stat.expired = {1'b0, elapsed} >= delay_ms;

endmodule

`default_nettype wire

FILE: rtl/context_id_allocator_with_reuse_delay.sv
// ----------------------------------------------------------------------------
// Context ID allocator with reuse delay
// Grants the lowest free context ID, stamps IDs as idle and frees idle IDs
// once the reuse delay has passed, bumping the version counters per free.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  req      in         req_tvalid/req_tready   req_tdata: command, id, now_ms
//  rsp      out        rsp_tvalid/rsp_tready   rsp_tdata, rsp_tuser, rsp_tlast
//  csr      in         csr_wr_en               csr_wr_data: reuse delay (s)
//
// Allocate, mark in use and mark idle each give one response.
// A tick scans one slot per cycle through the timestamp memory and the single
// expiry comparator, then closes.
// A freed-ID response waits for the output register, so a stall on rsp holds
// the scan. Reset is synchronous and clears the valid bits at once.
//
`default_nettype none

module context_id_allocator_with_reuse_delay (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [ciad_pkg::DELAY_W-1:0]     csr_wr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata from bit 0: command[1:0], context_id[5:2], now_ms[37:6], zeros
   input  wire logic [ciad_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata from bit 0: status[0], result_id[4:1], ids_waiting[5],
   // data_version[13:6], stable_version[21:14], zeros
   output logic [ciad_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: freed
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   ciad_pkg::state_type                 state_ff, state_in;
   logic [ciad_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic [ciad_pkg::ID_LIMIT:0]         in_use_ff, in_use_in;
   logic [ciad_pkg::VER_W-1:0]          data_version_ff, data_version_in;
   logic [ciad_pkg::VER_W-1:0]          stable_version_ff, stable_version_in;
   logic                                waiting_ff, waiting_in;
   logic [ciad_pkg::TIME_W-1:0]         now_ff, now_in;
   logic [ciad_pkg::DELAY_MS_W-1:0]     delay_ms_ff, delay_ms_in;
   logic [ciad_pkg::DELAY_W-1:0]        reuse_delay_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_status_ff, rsp_status_in;
   logic [ciad_pkg::ID_W-1:0]           rsp_id_ff, rsp_id_in;
   logic                                rsp_freed_ff, rsp_freed_in;
   logic                                rsp_waiting_ff, rsp_waiting_in;
   logic                                rsp_last_ff, rsp_last_in;

   ciad_pkg::command_type               req_command;
   logic [ciad_pkg::ID_W-1:0]           req_context_id;
   logic [ciad_pkg::TIME_W-1:0]         req_now_ms;

   logic                                out_free;
   logic                                alloc_found;
   logic [ciad_pkg::ID_W-1:0]           alloc_id;
   logic [ciad_pkg::ID_EXT_W-1:0]       cid_ext;
   logic [ciad_pkg::ID_EXT_W-1:0]       cid_off;
   logic                                cid_in_pool;
   logic [ciad_pkg::ID_EXT_W-1:0]       scan_id;
   logic                                scan_id_ok;
   logic                                last_slot;

   ciad_pkg::idle_ctrl_type             tbl_ctrl;
   ciad_pkg::idle_stat_type             tbl_stat;

   assign req_command    = ciad_pkg::command_type'(req_tdata[1:0]);
   assign req_context_id = req_tdata[5:2];
   assign req_now_ms     = req_tdata[37:6];

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Lowest free ID within the pool; IDs that do not fit in four bits are
   // never granted.
   always_comb begin
      alloc_found = 1'b0;
      alloc_id    = '0;
      for (int i = 0; i < ciad_pkg::ID_COUNT; i++) begin
         if (!alloc_found && (ciad_pkg::FIRST_ID + i <= ciad_pkg::ID_LIMIT) &&
             !in_use_ff[ciad_pkg::ID_W'(ciad_pkg::FIRST_ID + i)]) begin
            alloc_found = 1'b1;
            alloc_id    = ciad_pkg::ID_W'(ciad_pkg::FIRST_ID + i);
         end
      end
   end

   assign cid_ext     = {1'b0, req_context_id};
   assign cid_off     = cid_ext - ciad_pkg::ID_EXT_W'(ciad_pkg::FIRST_ID);
   assign cid_in_pool = (cid_ext >= ciad_pkg::ID_EXT_W'(ciad_pkg::FIRST_ID)) &&
                        (cid_off < ciad_pkg::ID_EXT_W'(ciad_pkg::ID_COUNT));

   assign scan_id    = ciad_pkg::ID_EXT_W'(ciad_pkg::FIRST_ID) +
                       ciad_pkg::ID_EXT_W'(slot_ff);
   assign scan_id_ok = scan_id <= ciad_pkg::ID_EXT_W'(ciad_pkg::ID_LIMIT);
   assign last_slot  = slot_ff == ciad_pkg::SLOT_W'(ciad_pkg::LAST_SLOT);

   always_comb begin
      state_in          = state_ff;
      slot_in           = slot_ff;
      in_use_in         = in_use_ff;
      data_version_in   = data_version_ff;
      stable_version_in = stable_version_ff;
      waiting_in        = waiting_ff;
      now_in            = now_ff;
      delay_ms_in       = delay_ms_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_status_in     = rsp_status_ff;
      rsp_id_in         = rsp_id_ff;
      rsp_freed_in      = rsp_freed_ff;
      rsp_waiting_in    = rsp_waiting_ff;
      rsp_last_in       = rsp_last_ff;

      req_tready        = 1'b0;
      tbl_ctrl.stamp_en = 1'b0;
      tbl_ctrl.clear_en = 1'b0;
      tbl_ctrl.wr_slot  = slot_ff;
      tbl_ctrl.stamp    = (req_now_ms == '0) ? ciad_pkg::TIME_W'(1) : req_now_ms;

      case (state_ff)
         ciad_pkg::ST_IDLE: begin
            req_tready       = out_free;
            tbl_ctrl.wr_slot = cid_off[ciad_pkg::SLOT_W-1:0];
            if (req_tvalid && out_free) begin
               rsp_status_in  = 1'b0;
               rsp_id_in      = '0;
               rsp_freed_in   = 1'b0;
               rsp_waiting_in = 1'b0;
               rsp_last_in    = 1'b1;
               case (req_command)
                  ciad_pkg::CMD_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     if (alloc_found) begin
                        in_use_in[alloc_id] = 1'b1;
                        rsp_id_in           = alloc_id;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  ciad_pkg::CMD_IN_USE: begin
                     rsp_valid_in      = 1'b1;
                     tbl_ctrl.clear_en = cid_in_pool;
                  end
                  ciad_pkg::CMD_IDLE: begin
                     rsp_valid_in      = 1'b1;
                     tbl_ctrl.stamp_en = cid_in_pool;
                  end
                  ciad_pkg::CMD_TICK: begin
                     now_in      = req_now_ms;
                     delay_ms_in = ciad_pkg::DELAY_MS_W'(reuse_delay_ff) *
                                   ciad_pkg::DELAY_MS_W'(ciad_pkg::MS_PER_S);
                     waiting_in  = 1'b0;
                     slot_in     = '0;
                     state_in    = ciad_pkg::ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ciad_pkg::ST_SCAN: begin
            if (tbl_stat.idle && tbl_stat.expired && scan_id_ok) begin
               // An expiring slot moves on only once its response can be
               // loaded into the output register.
               if (out_free) begin
                  in_use_in[scan_id[ciad_pkg::ID_W-1:0]] = 1'b0;
                  tbl_ctrl.clear_en = 1'b1;
                  data_version_in   = data_version_ff + 1'b1;
                  stable_version_in = stable_version_ff + 1'b1;
                  rsp_valid_in      = 1'b1;
                  rsp_status_in     = 1'b0;
                  rsp_id_in         = scan_id[ciad_pkg::ID_W-1:0];
                  rsp_freed_in      = 1'b1;
                  rsp_waiting_in    = 1'b0;
                  rsp_last_in       = 1'b0;
                  if (last_slot) begin
                     slot_in  = '0;
                     state_in = ciad_pkg::ST_CLOSE;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end
            end else begin
               waiting_in = waiting_ff || tbl_stat.idle;
               if (last_slot) begin
                  slot_in  = '0;
                  state_in = ciad_pkg::ST_CLOSE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ciad_pkg::ST_CLOSE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = 1'b0;
               rsp_id_in      = '0;
               rsp_freed_in   = 1'b0;
               rsp_waiting_in = waiting_ff;
               rsp_last_in    = 1'b1;
               state_in       = ciad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ciad_pkg::ST_IDLE;
         end
      endcase

      tbl_ctrl.rd_slot = slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ciad_pkg::ST_IDLE;
         slot_ff           <= '0;
         in_use_ff         <= '0;
         data_version_ff   <= '0;
         stable_version_ff <= '0;
         waiting_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         reuse_delay_ff    <= ciad_pkg::DELAY_RESET;
      end else begin
         state_ff          <= state_in;
         slot_ff           <= slot_in;
         in_use_ff         <= in_use_in;
         data_version_ff   <= data_version_in;
         stable_version_ff <= stable_version_in;
         waiting_ff        <= waiting_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_wr_en) begin
            reuse_delay_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      delay_ms_ff    <= delay_ms_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_waiting_ff <= rsp_waiting_in;
      rsp_last_ff    <= rsp_last_in;
   end

   ciad_idle_table u_idle_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .now_ms   (now_ff),
      .delay_ms (delay_ms_ff),
      .stat     (tbl_stat)
   );

   // The counters only change while the next response is loaded, so the held
   // response can show them directly.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_freed_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, stable_version_ff, data_version_ff, rsp_waiting_ff,
                        rsp_id_ff, rsp_status_ff};

   a_freed_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_freed_ff |-> !rsp_last_ff && !rsp_status_ff)
      else $error("freed response marked last or failed");

   a_versions_together: assert property (@(posedge clock) disable iff (reset)
      data_version_ff == stable_version_ff)
      else $error("version counters diverged");

   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_command == ciad_pkg::CMD_TICK)
      |=> state_ff == ciad_pkg::ST_SCAN && slot_ff == '0)
      else $error("tick did not start a scan at the first slot");

   a_free_bumps_version: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ciad_pkg::ST_SCAN) && tbl_ctrl.clear_en
      |=> data_version_ff == ciad_pkg::VER_W'($past(data_version_ff) + 1'b1) &&
          rsp_valid_ff && rsp_freed_ff)
      else $error("freed slot did not bump the version");

   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ciad_pkg::ST_IDLE && (!rsp_valid_ff || rsp_tready))
      else $error("request accepted while busy");

endmodule

`default_nettype wire
